/* rtl/core/spq_pkg.sv */
// shared types, constants and helpers of the sorted priority queue
package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int DATA_BITS = 32;
	localparam int PRIO_W    = 7;

	localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(99);

	typedef enum logic [0:0] {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} spq_cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_PLACE,
		S_HEAD,
		S_OUT
	} spq_state_t;

	typedef struct packed {
		spq_cmd_t           cmd;
		logic signed [31:0] data_value;
		logic [7:0]         priority_req;
	} spq_req_t;

	typedef struct packed {
		logic               head_valid;
		logic signed [31:0] head_data;
		logic [6:0]         head_priority;
		logic [4:0]         entry_count;
		spq_status_t        status;
	} spq_rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0]          prio;
		logic signed [DATA_BITS-1:0] data;
	} spq_entry_t;

	localparam int ENTRY_W = $bits(spq_entry_t);

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		spq_entry_t        wdata;
		logic [ADDR_W-1:0] raddr;
	} spq_mem_req_t;

	// logical slot to physical address in the circular buffer
	function automatic logic [ADDR_W-1:0] spq_phys(input logic [ADDR_W-1:0] base,
			input logic [ADDR_W-1:0] off);
		logic [ADDR_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (ADDR_W + 1)'(DEPTH)) begin
			sum = sum - (ADDR_W + 1)'(DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

/* rtl/core/spq_mem.sv */
// entry memory: one write port, one read port, registered read data
module spq_mem #(
	parameter int ADDR_BITS = 4,
	parameter int WIDTH     = 39
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/spq_ctrl.sv */
// sequencer: walks the sorted circular buffer one entry per cycle
module spq_ctrl
	import spq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  spq_req_t     req,
	output logic         done,
	output spq_rsp_t     rsp,
	output spq_mem_req_t mem_req,
	input  spq_entry_t   rd_entry
);

	spq_state_t        state_q, state_nxt;
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] idx_q;
	logic [PRIO_W-1:0] prio_q;
	logic signed [DATA_BITS-1:0] data_q;
	spq_status_t       status_q;

	logic              accept;
	logic              is_empty;
	logic              is_full;
	logic              shift;
	logic [PRIO_W-1:0] prio_in;
	logic [CNT_W-1:0]  count_m1;

	assign accept   = start && (state_q == S_IDLE);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign shift    = (rd_entry.prio > prio_q);
	assign prio_in  = (req.priority_req > {1'b0, PRIO_MAX}) ? PRIO_MAX
	                : req.priority_req[PRIO_W-1:0];
	assign count_m1 = count_q - CNT_W'(1);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.cmd == CMD_INSERT && !is_full && !is_empty) begin
						state_nxt = S_CMP;
					end else begin
						state_nxt = S_HEAD;
					end
				end
			end
			S_CMP: begin
				if (shift && idx_q == '0) begin
					state_nxt = S_PLACE;
				end else if (!shift) begin
					state_nxt = S_HEAD;
				end
			end
			S_PLACE: state_nxt = S_HEAD;
			S_HEAD:  state_nxt = S_OUT;
			S_OUT:   state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// memory accesses and outputs
	always_comb begin
		mem_req       = '0;
		mem_req.raddr = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.cmd == CMD_INSERT && !is_full) begin
					if (is_empty) begin
						mem_req.we         = 1'b1;
						mem_req.waddr      = head_q;
						mem_req.wdata.prio = prio_in;
						mem_req.wdata.data = DATA_BITS'(req.data_value);
					end else begin
						mem_req.raddr = spq_phys(head_q, count_m1[ADDR_W-1:0]);
					end
				end
			end
			S_CMP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = spq_phys(head_q, idx_q + ADDR_W'(1));
				if (shift) begin
					// move the less urgent entry one slot toward the tail
					mem_req.wdata = rd_entry;
					mem_req.raddr = spq_phys(head_q, idx_q - ADDR_W'(1));
				end else begin
					mem_req.wdata.prio = prio_q;
					mem_req.wdata.data = data_q;
				end
			end
			S_PLACE: begin
				mem_req.we         = 1'b1;
				mem_req.waddr      = head_q;
				mem_req.wdata.prio = prio_q;
				mem_req.wdata.data = data_q;
			end
			S_HEAD:  mem_req.raddr = head_q;
			S_OUT:   mem_req.raddr = head_q;
			default: mem_req.raddr = head_q;
		endcase

		busy               = (state_q != S_IDLE);
		done               = (state_q == S_OUT);
		rsp.head_valid     = !is_empty;
		rsp.head_data      = is_empty ? '0 : 32'(rd_entry.data);
		rsp.head_priority  = is_empty ? '0 : rd_entry.prio;
		rsp.entry_count    = 5'(count_q);
		rsp.status         = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			status_q <= ST_DONE;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_DONE;
						idx_q    <= count_m1[ADDR_W-1:0];
						if (req.cmd == CMD_INSERT) begin
							if (is_full) begin
								status_q <= ST_FULL;
							end else if (is_empty) begin
								count_q <= CNT_W'(1);
							end
						end else begin
							if (is_empty) begin
								status_q <= ST_EMPTY;
							end else begin
								head_q  <= spq_phys(head_q, ADDR_W'(1));
								count_q <= count_m1;
							end
						end
					end
				end
				S_CMP: begin
					if (!shift) begin
						count_q <= count_q + CNT_W'(1);
					end else if (idx_q != '0) begin
						idx_q <= idx_q - ADDR_W'(1);
					end
				end
				S_PLACE: count_q <= count_q + CNT_W'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prio_q <= prio_in;
			data_q <= DATA_BITS'(req.data_value);
		end
	end

endmodule

/* rtl/core/sorted_priority_queue_core.sv */
// top level of the sorted priority queue
//
// A command transfer happens on a rising edge with start high and busy low.
// req.cmd selects insert or remove; an insert carries a data word and a
// priority (smaller is more urgent, values above 99 are clamped to 99).
// Equal priorities leave in first-in first-out order.
// Every command gives one result: done is high for one cycle and rsp holds
// the head entry, the entry count and a status code (done, remove on empty
// queue, insert on full queue). The receiver cannot stall the result.
// Entries live in a circular buffer in one memory; a remove only advances
// the head pointer. A remove, a rejected command or an insert into an empty
// queue goes from the transfer through S_HEAD to S_OUT, which gives the
// result, and then back to S_IDLE for the next transfer. An insert into a
// nonempty queue first walks the memory from the tail one entry per cycle
// through its read port and its write port, then goes through S_HEAD and
// S_OUT. Reset empties the queue; memory contents are not cleared.
module sorted_priority_queue_core
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  spq_req_t req,
	output logic     done,
	output spq_rsp_t rsp
);

	spq_mem_req_t mem_req;
	spq_entry_t   rd_entry;
	logic [ENTRY_W-1:0] rd_bits;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.mem_req  (mem_req),
		.rd_entry (rd_entry)
	);

	spq_mem #(
		.ADDR_BITS (ADDR_W),
		.WIDTH     (ENTRY_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (rd_bits)
	);

	assign rd_entry = spq_entry_t'(rd_bits);

endmodule
